/* rtl/voxel_neighbourhood_classifier_defines.svh */
// Assertion macros used by the voxel classifier controller.
`ifndef VOXEL_NEIGHBOURHOOD_CLASSIFIER_DEFINES_SVH
`define VOXEL_NEIGHBOURHOOD_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define VNC_ASSERT_NOW(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("vnc assertion failed: same-cycle check");

// Next-cycle implication, checked outside reset.
`define VNC_ASSERT_NEXT(name, clk, rst, pre, post) \
   name: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("vnc assertion failed: next-cycle check");

`endif

/* rtl/vnc_pkg.sv */
package vnc_pkg;

   // Input command codes
   localparam logic CMD_WRITE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   // Node classes
   localparam logic [2:0] CLASS_INTERIOR_SOLID = 3'd0;
   localparam logic [2:0] CLASS_BOUNDARY_SOLID = 3'd1;
   localparam logic [2:0] CLASS_NEAR_WALL      = 3'd2;
   localparam logic [2:0] CLASS_BULK_FLUID     = 3'd3;
   localparam logic [2:0] CLASS_ENCLOSED_FLUID = 3'd4;

   // Configuration register indexes
   typedef enum logic [1:0] {
      REG_SIZE_X = 2'd0,
      REG_SIZE_Y = 2'd1,
      REG_SIZE_Z = 2'd2
   } csr_idx_type;

   localparam logic [6:0] SIZE_RESET = 7'd64;

   // Step codes along x and y
   localparam logic [1:0] STEP_ZERO = 2'b00;
   localparam logic [1:0] STEP_POS  = 2'b01;
   localparam logic [1:0] STEP_NEG  = 2'b11;

   // One row read per (dx, dy) column; z neighbours come out of the row word
   localparam int TAP_COUNT = 9;

   typedef struct packed {
      logic [1:0] dx;
      logic [1:0] dy;
      logic       use_zm;   // count the z-1 bit of the row
      logic       use_z0;   // count the z bit of the row
      logic       use_zp;   // count the z+1 bit of the row
      logic       centre;   // row holds the queried voxel itself
   } tap_type;

   typedef struct packed {
      logic       cmd;
      logic [5:0] pos_x;
      logic [5:0] pos_y;
      logic [5:0] pos_z;
      logic       solid_in;
   } req_payload_type;

   typedef struct packed {
      logic [2:0] node_class;
      logic       bad_coord;
   } rsp_payload_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic issue_read;
      logic write_voxel;
      logic clear_row;
   } dp_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic is_query;
      logic coord_ok;
      logic tap_last;
      logic clear_last;
   } dp_status_type;

   // Row reads of the 18 D3Q19 neighbours plus the centre
   function automatic tap_type tap_entry(input logic [3:0] idx);
      tap_type t;
      case (idx)
         4'd0:    t = '{STEP_ZERO, STEP_ZERO, 1'b1, 1'b0, 1'b1, 1'b1};
         4'd1:    t = '{STEP_POS,  STEP_ZERO, 1'b1, 1'b1, 1'b1, 1'b0};
         4'd2:    t = '{STEP_NEG,  STEP_ZERO, 1'b1, 1'b1, 1'b1, 1'b0};
         4'd3:    t = '{STEP_ZERO, STEP_POS,  1'b1, 1'b1, 1'b1, 1'b0};
         4'd4:    t = '{STEP_ZERO, STEP_NEG,  1'b1, 1'b1, 1'b1, 1'b0};
         4'd5:    t = '{STEP_POS,  STEP_POS,  1'b0, 1'b1, 1'b0, 1'b0};
         4'd6:    t = '{STEP_NEG,  STEP_NEG,  1'b0, 1'b1, 1'b0, 1'b0};
         4'd7:    t = '{STEP_POS,  STEP_NEG,  1'b0, 1'b1, 1'b0, 1'b0};
         4'd8:    t = '{STEP_NEG,  STEP_POS,  1'b0, 1'b1, 1'b0, 1'b0};
         default: t = '{STEP_ZERO, STEP_ZERO, 1'b0, 1'b0, 1'b0, 1'b0};
      endcase
      return t;
   endfunction

endpackage

/* rtl/vnc_dp.sv */
module vnc_dp #(
   parameter int MAX_DIM = 64
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [6:0]                size_x,
   input  logic [6:0]                size_y,
   input  logic [6:0]                size_z,
   input  vnc_pkg::req_payload_type  req_data,
   input  vnc_pkg::dp_cmd_type       cmd,
   output vnc_pkg::dp_status_type    status,
   output vnc_pkg::rsp_payload_type  result
);

   localparam int CW   = $clog2(MAX_DIM);
   localparam int WORD = 1 << CW;
   localparam int AW   = 2 * CW;
   localparam int ROWS = 1 << AW;
   localparam logic [8:0] MAXD = 9'(MAX_DIM);

   vnc_pkg::req_payload_type item_ff;
   vnc_pkg::tap_type         tap;

   logic [3:0]      tap_ff, tap_in;
   logic [AW-1:0]   clear_cnt_ff, clear_cnt_in;
   logic            rd_pending_ff;
   logic [WORD-1:0] row_q_ff;
   logic            use_m_ff, use_0_ff, use_p_ff, take_centre_ff;
   logic            centre_ff;
   logic [4:0]      adj_ff, solid_ff;

   logic [WORD-1:0] mem [ROWS];

   logic [8:0]    eff_x, eff_y, eff_z;
   logic [8:0]    px, py, pz, nx, ny;
   logic          x_ok, y_ok, zm_ok, zp_ok, coord_ok;
   logic [CW-1:0] zc, zm_idx, zp_idx;
   logic [AW-1:0] rd_addr, wr_addr;
   logic          bit_m, bit_0, bit_p;
   logic [1:0]    adj_inc, solid_inc;

   // Clamp the configured extents to the store size
   function automatic logic [8:0] eff_size(input logic [6:0] s);
      logic [8:0] w;
      w = {2'b00, s};
      return (w > MAXD) ? MAXD : w;
   endfunction

   assign eff_x = eff_size(size_x);
   assign eff_y = eff_size(size_y);
   assign eff_z = eff_size(size_z);

   assign px = {3'b000, item_ff.pos_x};
   assign py = {3'b000, item_ff.pos_y};
   assign pz = {3'b000, item_ff.pos_z};

   assign coord_ok = (px < eff_x) && (py < eff_y) && (pz < eff_z);

   // Neighbour column of the current tap
   assign tap = vnc_pkg::tap_entry(tap_ff);

   always_comb begin
      case (tap.dx)
         vnc_pkg::STEP_POS: begin
            nx   = px + 9'd1;
            x_ok = (px + 9'd1) < eff_x;
         end
         vnc_pkg::STEP_NEG: begin
            nx   = px - 9'd1;
            x_ok = (px != 9'd0);
         end
         default: begin
            nx   = px;
            x_ok = 1'b1;
         end
      endcase
      case (tap.dy)
         vnc_pkg::STEP_POS: begin
            ny   = py + 9'd1;
            y_ok = (py + 9'd1) < eff_y;
         end
         vnc_pkg::STEP_NEG: begin
            ny   = py - 9'd1;
            y_ok = (py != 9'd0);
         end
         default: begin
            ny   = py;
            y_ok = 1'b1;
         end
      endcase
   end

   assign zm_ok  = (pz != 9'd0);
   assign zp_ok  = (pz + 9'd1) < eff_z;
   assign zc     = CW'(item_ff.pos_z);
   assign zm_idx = zc - CW'(1);
   assign zp_idx = zc + CW'(1);

   assign rd_addr = {CW'(nx), CW'(ny)};
   assign wr_addr = {CW'(px), CW'(py)};

   // Capture the item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_ff <= req_data;
      end
   end

   // Voxel store: one row per (x, y), z along the word
   always_ff @(posedge clock) begin
      if (cmd.clear_row) begin
         mem[clear_cnt_ff] <= '0;
      end else if (cmd.write_voxel) begin
         mem[wr_addr][zc] <= item_ff.solid_in;
      end
      if (cmd.issue_read) begin
         row_q_ff <= mem[rd_addr];
      end
   end

   // Tap and clear counters
   assign tap_in       = cmd.load_item ? 4'd0 : (cmd.issue_read ? tap_ff + 4'd1 : tap_ff);
   assign clear_cnt_in = cmd.clear_row ? clear_cnt_ff + AW'(1) : clear_cnt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tap_ff        <= 4'd0;
         clear_cnt_ff  <= '0;
         rd_pending_ff <= 1'b0;
      end else begin
         tap_ff        <= tap_in;
         clear_cnt_ff  <= clear_cnt_in;
         rd_pending_ff <= cmd.issue_read;
      end
   end

   // Record which bits of the row being read count
   always_ff @(posedge clock) begin
      if (cmd.issue_read) begin
         use_m_ff       <= x_ok && y_ok && zm_ok && tap.use_zm;
         use_0_ff       <= x_ok && y_ok && tap.use_z0;
         use_p_ff       <= x_ok && y_ok && zp_ok && tap.use_zp;
         take_centre_ff <= tap.centre;
      end
   end

   // Accumulate neighbour counts as row words return
   assign bit_m     = use_m_ff & row_q_ff[zm_idx];
   assign bit_0     = use_0_ff & row_q_ff[zc];
   assign bit_p     = use_p_ff & row_q_ff[zp_idx];
   assign adj_inc   = 2'(use_m_ff) + 2'(use_0_ff) + 2'(use_p_ff);
   assign solid_inc = 2'(bit_m) + 2'(bit_0) + 2'(bit_p);

   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         adj_ff   <= 5'd0;
         solid_ff <= 5'd0;
      end else if (rd_pending_ff) begin
         adj_ff   <= adj_ff + 5'(adj_inc);
         solid_ff <= solid_ff + 5'(solid_inc);
         if (take_centre_ff) begin
            centre_ff <= row_q_ff[zc];
         end
      end
   end

   // Classify from the centre bit and the counts; a bad coordinate gives CLASS_INTERIOR_SOLID
   always_comb begin
      result.bad_coord = !coord_ok;
      if (!coord_ok) begin
         result.node_class = vnc_pkg::CLASS_INTERIOR_SOLID;
      end else if (centre_ff) begin
         result.node_class = (solid_ff == adj_ff) ? vnc_pkg::CLASS_INTERIOR_SOLID
                                                  : vnc_pkg::CLASS_BOUNDARY_SOLID;
      end else if (solid_ff == 5'd0) begin
         result.node_class = vnc_pkg::CLASS_BULK_FLUID;
      end else if (solid_ff < adj_ff) begin
         result.node_class = vnc_pkg::CLASS_NEAR_WALL;
      end else begin
         result.node_class = vnc_pkg::CLASS_ENCLOSED_FLUID;
      end
   end

   assign status.is_query   = (item_ff.cmd == vnc_pkg::CMD_QUERY);
   assign status.coord_ok   = coord_ok;
   assign status.tap_last   = (tap_ff == 4'(vnc_pkg::TAP_COUNT - 1));
   assign status.clear_last = &clear_cnt_ff;

endmodule

/* rtl/vnc_ctrl.sv */
`include "voxel_neighbourhood_classifier_defines.svh"

module vnc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   out_free,
   input  vnc_pkg::dp_status_type status,
   output vnc_pkg::dp_cmd_type    cmd,
   output logic                   load_result
);

   typedef enum logic [5:0] {
      S_IDLE     = 6'b000001,
      S_DISPATCH = 6'b000010,
      S_READ     = 6'b000100,
      S_DRAIN    = 6'b001000,
      S_FINISH   = 6'b010000,
      S_CLEAR    = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (status.clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) state_in = S_DISPATCH;
         end
         S_DISPATCH: begin
            if (!status.is_query) state_in = S_IDLE;
            else if (!status.coord_ok) state_in = S_FINISH;
            else state_in = S_READ;
         end
         S_READ: begin
            if (status.tap_last) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) state_in = S_IDLE;
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // Commands to the datapath
   assign req_ready       = (state_ff == S_IDLE);
   assign cmd.load_item   = req_ready && req_valid;
   assign cmd.issue_read  = (state_ff == S_READ);
   assign cmd.write_voxel = (state_ff == S_DISPATCH) && !status.is_query && status.coord_ok;
   assign cmd.clear_row   = (state_ff == S_CLEAR);
   assign load_result     = (state_ff == S_FINISH) && out_free;

   `VNC_ASSERT_NOW(a_clear_quiet, clock, reset, state_ff == S_CLEAR, !cmd.issue_read && !cmd.write_voxel && !req_ready)
   `VNC_ASSERT_NEXT(a_read_to_drain, clock, reset, cmd.issue_read && status.tap_last, state_ff == S_DRAIN)
   `VNC_ASSERT_NEXT(a_result_once, clock, reset, load_result, !load_result)

endmodule

/* rtl/voxel_neighbourhood_classifier.sv */
// Voxel neighbourhood classifier: holds a solid/fluid voxel grid and classifies
// voxels by their D3Q19 neighbours inside the configured grid.
// Request channel (req_valid/req_ready/req_data): cmd 0 writes solid_in to a
// voxel (no response, ignored outside the grid); cmd 1 queries one voxel.
// Response channel (rsp_valid/rsp_ready/rsp_data): one beat per query, with
// node_class and bad_coord set for a coordinate outside the grid.
// CSR port: csr_we writes csr_wdata to size_x/size_y/size_z (index 0..2);
// write only while idle. Sizes above MAX_DIM act as MAX_DIM.
// A valid query steps through DISPATCH, READ (one row read per tap), DRAIN and
// FINISH, and its result is then registered for rsp_valid; a bad query goes
// from DISPATCH to FINISH. A write lands in the store in DISPATCH after accept.
// Items are taken one at a time, a query paced by its store row reads.
// Reset: sizes return to 64 and the store is cleared to fluid by a pass of one
// row per cycle over all 2**(2*clog2(MAX_DIM)) rows (4096 at MAX_DIM 64),
// during which req_ready is low; CSR writes are taken throughout.
// A stalled response waits in the output register; the next request is still
// taken, and a following query holds its result until the register frees.
module voxel_neighbourhood_classifier #(
   parameter int MAX_DIM = 64
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  vnc_pkg::req_payload_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output vnc_pkg::rsp_payload_type rsp_data,
   input  logic                     csr_we,
   input  logic [1:0]               csr_addr,
   input  logic [6:0]               csr_wdata
);

   logic [6:0] size_x_ff, size_y_ff, size_z_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       out_free, load_result;

   vnc_pkg::rsp_payload_type rsp_data_ff, result;
   vnc_pkg::dp_cmd_type      cmd;
   vnc_pkg::dp_status_type   status;

   // Size registers
   always_ff @(posedge clock) begin
      if (reset) begin
         size_x_ff <= vnc_pkg::SIZE_RESET;
         size_y_ff <= vnc_pkg::SIZE_RESET;
         size_z_ff <= vnc_pkg::SIZE_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            vnc_pkg::REG_SIZE_X: size_x_ff <= csr_wdata;
            vnc_pkg::REG_SIZE_Y: size_y_ff <= csr_wdata;
            vnc_pkg::REG_SIZE_Z: size_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   vnc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .out_free    (out_free),
      .status      (status),
      .cmd         (cmd),
      .load_result (load_result)
   );

   vnc_dp #(
      .MAX_DIM (MAX_DIM)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .size_x   (size_x_ff),
      .size_y   (size_y_ff),
      .size_z   (size_z_ff),
      .req_data (req_data),
      .cmd      (cmd),
      .status   (status),
      .result   (result)
   );

   // Output register: hold the beat until taken
   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign rsp_valid_in = load_result ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_result) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* tb/testbench.sv */
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int GRID_DIM = 64;
   localparam int CHUNK_COUNT = 12;
   localparam int CHUNK_ITEMS = 170;
   localparam int SETTLE_CYCLES = 20;
   localparam int HOLD_CYCLES = 400;

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_ready;
   vnc_pkg::req_payload_type req_data;
   logic                     rsp_valid;
   logic                     rsp_ready;
   vnc_pkg::rsp_payload_type rsp_data;
   logic                     csr_we;
   logic [1:0]               csr_addr;
   logic [6:0]               csr_wdata;

   // Shadow copy of the voxel grid and the size registers
   bit              voxel_grid [0:GRID_DIM-1][0:GRID_DIM-1][0:GRID_DIM-1];
   logic [6:0]      grid_size_x;
   logic [6:0]      grid_size_y;
   logic [6:0]      grid_size_z;

   vnc_pkg::rsp_payload_type pending_classes [$];
   int              mismatch_count;
   int              send_idle_pct;
   int              recv_idle_pct;
   bit              hold_request;

   voxel_neighbourhood_classifier i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Give up if the run hangs
   initial begin
      #(10_000_000);
      $display("voxel_neighbourhood_classifier test failed");
      $finish;
   end

   function automatic int effective_size(input logic [6:0] s);
      return (s > GRID_DIM) ? GRID_DIM : int'(s);
   endfunction

   function automatic bit in_grid(input int x, input int y, input int z);
      return x >= 0 && x < effective_size(grid_size_x) &&
             y >= 0 && y < effective_size(grid_size_y) &&
             z >= 0 && z < effective_size(grid_size_z);
   endfunction

   // Count the in-grid face and edge neighbours and how many are solid, then classify
   function automatic logic [2:0] classify_voxel(input int x, input int y, input int z);
      int adj;
      int solid;
      int reach;
      adj = 0;
      solid = 0;
      for (int dx = -1; dx <= 1; dx++) begin
         for (int dy = -1; dy <= 1; dy++) begin
            for (int dz = -1; dz <= 1; dz++) begin
               reach = (dx != 0) + (dy != 0) + (dz != 0);
               if (reach >= 1 && reach <= 2 && in_grid(x + dx, y + dy, z + dz)) begin
                  adj++;
                  solid += voxel_grid[x + dx][y + dy][z + dz];
               end
            end
         end
      end
      if (voxel_grid[x][y][z])
         return (solid == adj) ? vnc_pkg::CLASS_INTERIOR_SOLID
                               : vnc_pkg::CLASS_BOUNDARY_SOLID;
      if (solid == 0)
         return vnc_pkg::CLASS_BULK_FLUID;
      if (solid < adj)
         return vnc_pkg::CLASS_NEAR_WALL;
      return vnc_pkg::CLASS_ENCLOSED_FLUID;
   endfunction

   // Apply one accepted request to the shadow grid, queue its response if any
   task automatic predict_request(input vnc_pkg::req_payload_type item);
      vnc_pkg::rsp_payload_type want;
      bit ok;
      ok = in_grid(item.pos_x, item.pos_y, item.pos_z);
      if (item.cmd == vnc_pkg::CMD_WRITE) begin
         if (ok)
            voxel_grid[item.pos_x][item.pos_y][item.pos_z] = item.solid_in;
      end else begin
         // class field reads as zero on a bad coordinate
         want.node_class = ok ? classify_voxel(item.pos_x, item.pos_y, item.pos_z)
                              : vnc_pkg::CLASS_INTERIOR_SOLID;
         want.bad_coord = !ok;
         pending_classes = {pending_classes, want};
      end
   endtask

   function automatic vnc_pkg::req_payload_type make_req(input logic cmd, input int x,
                                                         input int y, input int z,
                                                         input logic solid);
      vnc_pkg::req_payload_type item;
      item.cmd = cmd;
      item.pos_x = x[5:0];
      item.pos_y = y[5:0];
      item.pos_z = z[5:0];
      item.solid_in = solid;
      return item;
   endfunction

   // Offer one beat, optionally after a gap, and return at the falling edge after accept
   task automatic send_item(input vnc_pkg::req_payload_type item);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_data <= item;
      req_valid <= 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_request(item);
      @(negedge clock);
   endtask

   // Drop valid, drain every expected beat, then let the block settle
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_classes.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic program_grid(input logic [6:0] sx, input logic [6:0] sy,
                               input logic [6:0] sz);
      wait_idle();
      csr_we <= 1'b1;
      csr_addr <= vnc_pkg::REG_SIZE_X;
      csr_wdata <= sx;
      @(negedge clock);
      csr_addr <= vnc_pkg::REG_SIZE_Y;
      csr_wdata <= sy;
      @(negedge clock);
      csr_addr <= vnc_pkg::REG_SIZE_Z;
      csr_wdata <= sz;
      @(negedge clock);
      csr_we <= 1'b0;
      grid_size_x = sx;
      grid_size_y = sy;
      grid_size_z = sz;
   endtask

   // Reset sizes, corner and far corner of the full grid
   task automatic test_default_grid();
      send_item(make_req(vnc_pkg::CMD_QUERY, 0, 0, 0, 1'b1));
      send_item(make_req(vnc_pkg::CMD_WRITE, 63, 63, 63, 1'b1));
      send_item(make_req(vnc_pkg::CMD_QUERY, 63, 63, 63, 1'b0));
      send_item(make_req(vnc_pkg::CMD_QUERY, 62, 63, 63, 1'b0));
   endtask

   // Walk a 2x2x2 grid through each class but bulk fluid, and the out-of-grid cases
   task automatic test_node_classes();
      program_grid(7'd2, 7'd2, 7'd2);
      for (int x = 0; x < 2; x++)
         for (int y = 0; y < 2; y++)
            for (int z = 0; z < 2; z++)
               if (x + y + z <= 2)
                  send_item(make_req(vnc_pkg::CMD_WRITE, x, y, z, 1'b1));
      send_item(make_req(vnc_pkg::CMD_QUERY, 0, 0, 0, 1'b0));
      send_item(make_req(vnc_pkg::CMD_WRITE, 0, 0, 0, 1'b0));
      send_item(make_req(vnc_pkg::CMD_QUERY, 0, 0, 0, 1'b0));
      send_item(make_req(vnc_pkg::CMD_WRITE, 1, 1, 0, 1'b0));
      send_item(make_req(vnc_pkg::CMD_QUERY, 0, 0, 0, 1'b0));
      send_item(make_req(vnc_pkg::CMD_QUERY, 1, 0, 0, 1'b0));
      send_item(make_req(vnc_pkg::CMD_QUERY, 2, 0, 0, 1'b0));
      send_item(make_req(vnc_pkg::CMD_WRITE, 0, 2, 0, 1'b1));
      send_item(make_req(vnc_pkg::CMD_QUERY, 0, 1, 2, 1'b1));
   endtask

   // A grid of one voxel has no neighbours at all
   task automatic test_single_voxel();
      program_grid(7'd1, 7'd1, 7'd1);
      send_item(make_req(vnc_pkg::CMD_QUERY, 0, 0, 0, 1'b0));
      send_item(make_req(vnc_pkg::CMD_WRITE, 0, 0, 0, 1'b1));
      send_item(make_req(vnc_pkg::CMD_QUERY, 0, 0, 0, 1'b0));
      send_item(make_req(vnc_pkg::CMD_QUERY, 1, 0, 0, 1'b0));
      send_item(make_req(vnc_pkg::CMD_WRITE, 0, 0, 0, 1'b0));
   endtask

   // Empty grid ignores writes; oversized registers act as the full grid
   task automatic test_size_extremes();
      program_grid(7'd0, 7'd0, 7'd0);
      send_item(make_req(vnc_pkg::CMD_WRITE, 0, 0, 0, 1'b1));
      send_item(make_req(vnc_pkg::CMD_QUERY, 0, 0, 0, 1'b0));
      program_grid(7'd127, 7'd127, 7'd127);
      send_item(make_req(vnc_pkg::CMD_QUERY, 0, 0, 0, 1'b0));
      send_item(make_req(vnc_pkg::CMD_QUERY, 63, 63, 63, 1'b1));
   endtask

   function automatic logic [6:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 3)  return 7'd0;
      if (r < 8)  return 7'd127;
      if (r < 14) return 7'd64;
      if (r < 20) return 7'($urandom_range(65, 126));
      if (r < 35) return 7'($urandom_range(9, 63));
      return 7'($urandom_range(1, 6));
   endfunction

   // Keep activity in a small box so that solids cluster; small grids run past the edge
   function automatic int pick_box_low(input int eff);
      if (eff <= 8)
         return 0;
      return $urandom_range(1) ? eff - 5 : $urandom_range(0, eff - 6);
   endfunction

   function automatic int pick_coord(input int eff, input int low);
      int c;
      if ($urandom_range(99) < 10)
         return $urandom_range(63);
      c = (eff <= 8) ? $urandom_range(0, eff) : low + $urandom_range(0, 5);
      return (c > 63) ? 63 : c;
   endfunction

   // Random mix of writes and queries in a busy box
   task automatic run_traffic(input int items, input int solid_pct);
      int lo_x;
      int lo_y;
      int lo_z;
      logic cmd;
      lo_x = pick_box_low(effective_size(grid_size_x));
      lo_y = pick_box_low(effective_size(grid_size_y));
      lo_z = pick_box_low(effective_size(grid_size_z));
      for (int i = 0; i < items; i++) begin
         cmd = ($urandom_range(99) < 55) ? vnc_pkg::CMD_WRITE : vnc_pkg::CMD_QUERY;
         send_item(make_req(cmd,
                            pick_coord(effective_size(grid_size_x), lo_x),
                            pick_coord(effective_size(grid_size_y), lo_y),
                            pick_coord(effective_size(grid_size_z), lo_z),
                            $urandom_range(99) < solid_pct));
      end
   endtask

   // Hold the response side for a long stretch while requests keep coming
   task automatic test_backpressure();
      program_grid(7'd4, 7'd4, 7'd4);
      hold_request = 1'b1;
      run_traffic(30, 70);
   endtask

   task automatic test_random_traffic();
      for (int chunk = 0; chunk < CHUNK_COUNT; chunk++) begin
         case (chunk / 4)
            0: begin
               send_idle_pct = 17;
               recv_idle_pct = 61;
            end
            1: begin
               send_idle_pct = 61;
               recv_idle_pct = 17;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         program_grid(pick_size(), pick_size(), pick_size());
         run_traffic(CHUNK_ITEMS, $urandom_range(20, 95));
      end
   endtask

   // Response side: random stalls, plus a long hold when asked
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Compare each response beat with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_classes.size() == 0) begin
            $display("%0t: unexpected response, actual class %0d bad %0b",
                     $time, rsp_data.node_class, rsp_data.bad_coord);
            mismatch_count++;
         end else begin
            if (rsp_data.node_class !== pending_classes[0].node_class) begin
               $display("%0t: node_class expected %0d actual %0d", $time,
                        pending_classes[0].node_class, rsp_data.node_class);
               mismatch_count++;
            end
            if (rsp_data.bad_coord !== pending_classes[0].bad_coord) begin
               $display("%0t: bad_coord expected %0b actual %0b", $time,
                        pending_classes[0].bad_coord, rsp_data.bad_coord);
               mismatch_count++;
            end
            void'(pending_classes.pop_front());
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_addr = vnc_pkg::REG_SIZE_X;
      csr_wdata = '0;
      grid_size_x = vnc_pkg::SIZE_RESET;
      grid_size_y = vnc_pkg::SIZE_RESET;
      grid_size_z = vnc_pkg::SIZE_RESET;
      mismatch_count = 0;
      hold_request = 1'b0;
      send_idle_pct = 17;
      recv_idle_pct = 61;
      repeat (3) @(negedge clock);
      reset <= 1'b0;

      test_default_grid();
      test_node_classes();
      test_single_voxel();
      test_size_extremes();
      test_backpressure();
      test_random_traffic();
      wait_idle();

      if (mismatch_count == 0)
         $display("voxel_neighbourhood_classifier test passed");
      else
         $display("voxel_neighbourhood_classifier test failed");
      $finish;
   end

endmodule
